[design/cdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque package
// Sizes, codes and beat types shared by the deque controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned CAP_RESET   = (DEPTH < 16) ? DEPTH : 16;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [VALUE_WIDTH-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]                    status;
    logic signed [VALUE_WIDTH-1:0] pop_value;
    logic [CNT_W-1:0]              fill_count;
  } out_beat_t;

endpackage
`default_nettype wire

[design/circular_double_ended_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Ring-buffer deque with push/pop at either end and a programmable capacity.
// ----------------------------------------------------------------------------
// Each input beat is captured on acceptance, then executed (the indexes are
// updated and the ring memory, whose read data is registered, is accessed),
// then its result is presented and held for as long as out_ready_i is low; a
// new beat is accepted on the cycle after the result is taken, so the block
// takes no new beat before the last one is through, as set by the single-item
// controller sequence. The ring has no clearing pass and is usable right
// after reset. Capacity (register 0) is clamped to 1..16; writing it empties
// the deque.
module circular_double_ended_queue
  import cdq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_beat_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_beat_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  ctrl_cmd_t        cmd;
  cfg_wr_t          cfg_wr;
  logic [CNT_W-1:0] cap;
  logic             hit_cap;

  assign pready       = 1'b1;
  assign hit_cap      = (paddr[2] == REG_CAPACITY);
  assign cfg_wr.en    = psel & penable & pwrite & pready & hit_cap;
  assign cfg_wr.value = pwdata[CNT_W-1:0];
  assign prdata       = hit_cap ? {{(32 - CNT_W){1'b0}}, cap} : '0;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  cdq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_wr_i   (cfg_wr),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cap_o      (cap)
  );

endmodule
`default_nettype wire

[design/cdq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences one beat at a time: capture, execute, present the result.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ctrl_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/cdq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque datapath
// Ring storage, head and tail indexes, fill count, capacity register and the
// result register.
// ----------------------------------------------------------------------------
module cdq_dp
  import cdq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  input  wire cfg_wr_t   cfg_wr_i,
  input  wire in_beat_t  in_data_i,
  output out_beat_t      out_data_o,
  output logic [CNT_W-1:0] cap_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q;

  logic [1:0]             act_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]       count_q, count_d, cap_q, cap_d;
  logic [1:0]             status_q, status_d;
  logic                   pop_ok_q, pop_ok_d;
  logic [CNT_W-1:0]       fill_q;

  logic                   wr_en, rd_en;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  logic [IDX_W-1:0]       head_up, head_dn, tail_up, tail_dn;
  logic                   full, empty;

  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] idx,
                                                logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt >= cap) ? '0 : IDX_W'(nxt);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] idx,
                                                  logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] cm1;
    cm1 = cap - CNT_W'(1);
    return (idx == '0) ? IDX_W'(cm1) : idx - IDX_W'(1);
  endfunction

  assign head_up = step_up(head_q, cap_q);
  assign head_dn = step_down(head_q, cap_q);
  assign tail_up = step_up(tail_q, cap_q);
  assign tail_dn = step_down(tail_q, cap_q);
  assign full    = (count_q >= cap_q);
  assign empty   = (count_q == '0);

  always_comb begin
    cap_d = cap_q;
    if (cfg_wr_i.en) begin
      if (cfg_wr_i.value == '0) begin
        cap_d = CNT_W'(1);
      end else if (cfg_wr_i.value > CNT_W'(DEPTH)) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = cfg_wr_i.value;
      end
    end
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = STAT_DONE;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_q;
    rd_addr  = head_q;
    case (act_q)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          head_d  = head_dn;
          wr_en   = cmd_i.exec;
          wr_addr = head_dn;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_PUSH_REAR: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          tail_d  = tail_up;
          wr_en   = cmd_i.exec;
          wr_addr = tail_q;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          head_d   = head_up;
          rd_en    = cmd_i.exec;
          rd_addr  = head_q;
          pop_ok_d = 1'b1;
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          tail_d   = tail_dn;
          rd_en    = cmd_i.exec;
          rd_addr  = tail_dn;
          pop_ok_d = 1'b1;
          count_d  = count_q - CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CNT_W'(CAP_RESET);
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_wr_i.en) begin
      cap_q   <= cap_d;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_data_i.action;
      val_q <= in_data_i.push_value;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
      fill_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= val_q;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  assign out_data_o.status     = status_q;
  assign out_data_o.pop_value  = pop_ok_q ? rd_data_q : '0;
  assign out_data_o.fill_count = fill_q;
  assign cap_o                 = cap_q;

  count_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q) else $error("fill count above capacity");

  head_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(head_q) < cap_q) else $error("head index outside ring");

  tail_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(tail_q) < cap_q) else $error("tail index outside ring");

endmodule
`default_nettype wire
